// File: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   `ASSERT_CLK(label, clk, rst, !(expr), msg)

`endif

// File: hdl/ssd_pkg.sv
`timescale 1ns / 1ps

package ssd_pkg;

   // field widths
   localparam int VALUE_W = 64;
   localparam int CHAR_W  = 8;

   // decimal digits needed for a magnitude up to 2^63
   localparam int DIGITS   = 19;
   localparam int DIGIT_W  = 4;
   localparam int BCD_W    = DIGITS * DIGIT_W;
   localparam int BIT_CNT_W = $clog2(VALUE_W + 1);
   localparam int DIG_CNT_W = $clog2(DIGITS + 1);

   // characters
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // control from the sequencer to the digit shifter
   typedef struct packed {
      logic load;
      logic shift;
   } emit_ctl_type;

   // status from the digit shifter
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               lone;
   } emit_stat_type;

endpackage

// File: hdl/ssd_dabble.sv
`timescale 1ns / 1ps

module ssd_dabble
   import ssd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] mag,
   output logic               busy,
   output logic [BCD_W-1:0]   bcd
);

   logic [VALUE_W-1:0]   mag_ff;
   logic [VALUE_W-1:0]   mag_in;
   logic [BCD_W-1:0]     bcd_ff;
   logic [BCD_W-1:0]     bcd_in;
   logic [BCD_W-1:0]     adj;
   logic [BIT_CNT_W-1:0] cnt_ff;
   logic [BIT_CNT_W-1:0] cnt_in;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // one magnitude bit enters the digit register per cycle, msb first
   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (start) begin
         mag_in = mag;
         bcd_in = '0;
         cnt_in = BIT_CNT_W'(VALUE_W);
      end else if (busy) begin
         mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign busy = (cnt_ff != '0);
   assign bcd  = bcd_ff;

endmodule

// File: hdl/ssd_emit.sv
`timescale 1ns / 1ps

module ssd_emit
   import ssd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  emit_ctl_type  ctl,
   input  logic [BCD_W-1:0] bcd,
   output emit_stat_type stat
);

   logic [BCD_W-1:0]     dig_ff;
   logic [BCD_W-1:0]     dig_in;
   logic [DIG_CNT_W-1:0] rem_ff;
   logic [DIG_CNT_W-1:0] rem_in;

   // digit shifter, top digit goes out first
   always_comb begin
      dig_in = dig_ff;
      rem_in = rem_ff;
      if (ctl.load) begin
         dig_in = bcd;
         rem_in = DIG_CNT_W'(DIGITS);
      end else if (ctl.shift) begin
         dig_in = {dig_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      dig_ff <= dig_in;
   end

   assign stat.digit = dig_ff[BCD_W-1 -: DIGIT_W];
   assign stat.lone  = (rem_ff == DIG_CNT_W'(1));

endmodule

// File: hdl/signed_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps

// channel  | direction | ports
// req      | in        | req_valid, req_ready, req_value (64 bit signed)
// rsp      | out       | rsp_valid, rsp_ready, rsp_character (8 bit), rsp_last
//
// one value at a time: the conversion runs the bit-serial shift-and-adjust
// steps, one per magnitude bit, then the leading-zero scan and output of the
// 19 digit positions, with a leading minus first when the word is negative.
// a stalled rsp holds the sequencer; the last character
// may wait in the output register while the next word is taken.
// synchronous reset clears the sequencer, the bit counter and rsp_valid.

module signed_binary_to_decimal_ascii
   import ssd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CHAR_W-1:0]        rsp_character,
   output logic                     rsp_last
);

   state_type            state_ff;
   state_type            state_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic [VALUE_W-1:0]   raw;
   logic [VALUE_W-1:0]   mag;
   logic                 dab_start;
   logic                 dab_busy;
   logic [BCD_W-1:0]     dab_bcd;
   emit_ctl_type         emit_ctl;
   emit_stat_type        emit_stat;
   logic                 slot_free;
   logic                 out_load;
   logic [CHAR_W-1:0]    out_char;
   logic                 out_last;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic [CHAR_W-1:0]    rsp_char_in;
   logic                 rsp_last_ff;
   logic                 rsp_last_in;
   logic                 accept;
   logic                 zero_lead;

   // magnitude in unsigned arithmetic, 2^63 stays exact
   assign raw = VALUE_W'(req_value);
   assign mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign zero_lead = (emit_stat.digit == '0) && !emit_stat.lone;

   ssd_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dab_start),
      .mag   (mag),
      .busy  (dab_busy),
      .bcd   (dab_bcd)
   );

   ssd_emit u_emit (
      .clock (clock),
      .reset (reset),
      .ctl   (emit_ctl),
      .bcd   (dab_bcd),
      .stat  (emit_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (!dab_busy) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!zero_lead) state_in = neg_ff ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (slot_free) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free && emit_stat.lone) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      dab_start      = 1'b0;
      emit_ctl.load  = 1'b0;
      emit_ctl.shift = 1'b0;
      out_load       = 1'b0;
      out_char       = CHAR_ZERO;
      out_last       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            dab_start = req_valid;
         end
         ST_CONVERT: begin
            emit_ctl.load = !dab_busy;
         end
         ST_SKIP: begin
            emit_ctl.shift = zero_lead;
         end
         ST_SIGN: begin
            out_load = slot_free;
            out_char = CHAR_MINUS;
         end
         ST_EMIT: begin
            out_load       = slot_free;
            out_char       = CHAR_ZERO + CHAR_W'(emit_stat.digit);
            out_last       = emit_stat.lone;
            emit_ctl.shift = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // sign kept for the leading minus
   assign neg_in = accept ? raw[VALUE_W-1] : neg_ff;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_char;
         rsp_last_in  = out_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: hdl/ssd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssd_checker
   import ssd_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [CHAR_W-1:0]         rsp_character,
   input logic                      rsp_last
);

   // a stalled word holds
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last), "rsp word changed while stalled")

   // only minus or a digit comes out
   `ASSERT_CLK(a_rsp_char, clock, reset, rsp_valid |-> (rsp_character == CHAR_MINUS) || ((rsp_character >= CHAR_ZERO) && (rsp_character <= CHAR_NINE)), "rsp character out of range")

   // the sign never ends a run
   `ASSERT_NEVER(a_minus_last, clock, reset, rsp_valid && (rsp_character == CHAR_MINUS) && rsp_last, "minus flagged as last")

   // one word at a time: no accept right after an accept
   `ASSERT_CLK(a_req_gap, clock, reset, req_valid && req_ready |=> !req_ready, "req taken while converting")

endmodule

bind signed_binary_to_decimal_ascii ssd_checker u_ssd_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import ssd_pkg::*;
;

   localparam int          CLK_HALF     = 10;
   localparam int          RESET_CYCLES = 12;
   localparam int          RANDOM_WORDS = 350;
   localparam int          PAUSE_AT     = 150;
   localparam int          IDLE_LIMIT   = 2000;
   localparam int          TAIL_CYCLES  = 100;
   localparam int          MAX_CHARS    = 20;
   localparam logic [63:0] DEC_BASE     = 64'd10;

   // one directed row: word and its text, empty text means use the predictor
   typedef struct {
      logic [VALUE_W-1:0] value;
      string              text;
   } text_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [CHAR_W-1:0]         rsp_character;
   logic                      rsp_last;

   // expected characters, {last, character}
   logic [CHAR_W:0] pending_chars[$];

   int           error_count = 0;
   int           words_sent = 0;
   int           negative_words = 0;
   int           chars_seen = 0;
   int           full_length_words = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;
   int           stall_mode = 0;
   int           stall_count = 0;
   text_row_type directed_rows[20];

   signed_binary_to_decimal_ascii i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #CLK_HALF clock = ~clock;

   // decimal text of a word, most significant character first
   task automatic queue_decimal(input logic [VALUE_W-1:0] raw);
      logic [VALUE_W-1:0] magnitude;
      logic [VALUE_W-1:0] remainder;
      logic [CHAR_W-1:0]  digit_chars[MAX_CHARS];
      int                 ndigits;
      int                 k;
      magnitude = raw[VALUE_W-1] ? (~raw + 64'd1) : raw;
      ndigits = 0;
      do begin
         remainder = magnitude % DEC_BASE;
         digit_chars[ndigits] = CHAR_ZERO + remainder[CHAR_W-1:0];
         magnitude = magnitude / DEC_BASE;
         ndigits++;
      end while (magnitude != 0 && ndigits < MAX_CHARS);
      if (raw[VALUE_W-1]) begin
         pending_chars.push_back({1'b0, CHAR_MINUS});
      end
      for (k = ndigits - 1; k >= 0; k--) begin
         pending_chars.push_back({(k == 0), digit_chars[k]});
      end
      if (ndigits + int'(raw[VALUE_W-1]) == MAX_CHARS) full_length_words++;
   endtask

   // text typed into the directed table
   task automatic queue_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++) begin
         pending_chars.push_back({(i == text.len() - 1), text[i]});
      end
      if (text.len() == MAX_CHARS) full_length_words++;
   endtask

   // offer one word, hold it until taken, then pace the next burst
   task automatic send_word(input logic [VALUE_W-1:0] value, input string text);
      int gap;
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      if (text.len() == 0) begin
         queue_decimal(value);
      end else begin
         queue_text(text);
      end
      words_sent++;
      if (value[VALUE_W-1]) negative_words++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // long bursts now and then leave the sender with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(0, 6);
         gap = $urandom_range(1, 100);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random word of random magnitude, with bias toward powers of ten
   function automatic logic [VALUE_W-1:0] random_word();
      logic [VALUE_W-1:0] word;
      logic [VALUE_W-1:0] power;
      int                 nbits;
      int                 k;
      case ($urandom_range(0, 3))
         0: begin
            word = {$urandom, $urandom};
         end
         1: begin
            power = 64'd1;
            for (k = $urandom_range(0, 18); k > 0; k--) power = power * DEC_BASE;
            word = power + 64'($urandom_range(0, 2)) - 64'd1;
            if ($urandom_range(0, 1) == 1) word = ~word + 64'd1;
         end
         default: begin
            nbits = $urandom_range(1, VALUE_W);
            word = {$urandom, $urandom} >> (VALUE_W - nbits);
            if ($urandom_range(0, 1) == 1) word = ~word + 64'd1;
         end
      endcase
      return word;
   endfunction

   // stimulus
   initial begin
      int i;
      directed_rows = '{
         '{64'd0, "0"},
         '{64'd1, "1"},
         '{-64'sd1, "-1"},
         '{64'd9, "9"},
         '{64'd10, "10"},
         '{-64'sd10, "-10"},
         '{64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
         '{64'h8000_0000_0000_0000, "-9223372036854775808"},
         '{64'h8000_0000_0000_0001, "-9223372036854775807"},
         '{64'h7FFF_FFFF_FFFF_FFFE, ""},
         '{64'd1000000000000000000, "1000000000000000000"},
         '{64'd999999999999999999, ""},
         '{-64'sd1000000000000000000, ""},
         '{64'h5555_5555_5555_5555, ""},
         '{64'hAAAA_AAAA_AAAA_AAAA, ""},
         '{64'd99, ""},
         '{64'd100, ""},
         '{64'd12345, ""},
         '{64'd4294967296, ""},
         '{-64'sd4294967296, ""}
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].value, directed_rows[r].text);
      end

      for (i = 0; i < RANDOM_WORDS; i++) begin
         // hold the sender off until the block has drained completely
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_chars.size() != 0);
         end
         send_word(random_word(), "");
      end
      req_valid <= 1'b0;

      // drain, then let the block settle
      do @(posedge clock); while (pending_chars.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d words sent (%0d negative, %0d of full length), %0d characters checked",
               words_sent, negative_words, full_length_words, chars_seen);
      $display("directed extremes and zero, then random magnitudes near powers of ten");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // receiver stall pattern in one of four modes, redrawn at random as the stall counter wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count % 128 == 127) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= (stall_count % 4 == 3);
            default: rsp_ready <= (stall_count % 32 >= 20);
         endcase
      end
   end

   // character checker
   always @(posedge clock) begin
      logic [CHAR_W:0] expected;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_seen++;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character %0d last %0b", $time, rsp_character,
                     rsp_last);
            error_count++;
         end else begin
            expected = pending_chars.pop_front();
            if (rsp_character !== expected[CHAR_W-1:0]) begin
               $display("%0t: character expected %0d actual %0d", $time,
                        expected[CHAR_W-1:0], rsp_character);
               error_count++;
            end
            if (rsp_last !== expected[CHAR_W]) begin
               $display("%0t: last expected %0b actual %0b", $time, expected[CHAR_W],
                        rsp_last);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d characters pending", $time,
                     IDLE_LIMIT, pending_chars.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/ssd_pkg.sv
hdl/ssd_dabble.sv
hdl/ssd_emit.sv
hdl/signed_binary_to_decimal_ascii.sv
hdl/ssd_checker.sv
tb/sv/tb_top.sv
